// ===== hw/rtl/fcrs_pkg.sv =====
// Package for the filled circle row span block: screen size, field widths,
// register indexes, reset values, pipeline types and the root digit step.
// No dependencies.
package fcrs_pkg;

  localparam int SCREEN_WIDTH  = 640;
  localparam int SCREEN_HEIGHT = 480;

  localparam int ROW_W     = 9;
  localparam int COL_W     = 10;
  localparam int CY_W      = 9;
  localparam int RAD_W     = 10;
  localparam int COLOR_W   = 8;
  localparam int CFG_W     = 10;
  localparam int CFG_IDX_W = 3;

  // radicand, root and the width that holds screen-size compares
  localparam int V_W    = 2 * RAD_W;
  localparam int ROOT_W = RAD_W;
  localparam int EXT_W  = 13;

  // root digits: STEPS_PER_STAGE * SQRT_STAGES must equal ROOT_W
  localparam int STEPS_PER_STAGE = 2;
  localparam int SQRT_STAGES     = ROOT_W / STEPS_PER_STAGE;

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 40;
  localparam int OUT_USER_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X   = 3'd0,
    REG_CENTER_Y   = 3'd1,
    REG_RADIUS     = 3'd2,
    REG_FILL_COLOR = 3'd3
  } cfg_reg_e;

  localparam logic [COL_W-1:0]   CENTER_X_RST   = 10'd320;
  localparam logic [CY_W-1:0]    CENTER_Y_RST   = 9'd240;
  localparam logic [RAD_W-1:0]   RADIUS_RST     = 10'd100;
  localparam logic [COLOR_W-1:0] FILL_COLOR_RST = 8'h30 | 8'h80;

  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic              in_band;
    logic [V_W-1:0]    x;   // remainder v - q^2 (scaled)
    logic [ROOT_W-1:0] q;   // root bits found so far
  } sqrt_stage_t;

  // One restoring digit of the integer square root at bit position i.
  function automatic sqrt_stage_t sqrt_step(sqrt_stage_t s, int unsigned i);
    sqrt_stage_t      r;
    logic [V_W+1:0]   trial;
    r     = s;
    trial = {{(V_W - ROOT_W){1'b0}}, s.q, 2'b01} << (2 * i);
    if ({2'b00, s.x} >= trial) begin
      r.x = s.x - trial[V_W-1:0];
      r.q = {s.q[ROOT_W-2:0], 1'b1};
    end else begin
      r.q = {s.q[ROOT_W-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/filled_circle_row_span_top.sv =====
// Filled circle row span: pipelined span generator with configuration registers.
// Depends on fcrs_pkg.

// Takes one row index per beat and returns, one beat per row, the clipped span
// [span_start, span_end) that a filled circle covers on that row, plus the fill
// color. Throughput is one row per cycle while the output is not held. From
// input beat to output beat a row passes the band-test and squares stages,
// the ten-digit integer square root (two digits per stage) and clipping.
// Each stage holds only while it is full and the next one cannot take its
// beat, so bubbles close up under back-pressure. Write center, radius and
// color through the cfg port only while no row is in flight.
module filled_circle_row_span_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [fcrs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [fcrs_pkg::CFG_W-1:0]      cfg_wdata_i,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [fcrs_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,   // row[8:0], zero pad
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // row_out[8:0], span_start[18:9], span_end[28:19], pixel_color[36:29], pad
  output logic [fcrs_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  output logic [fcrs_pkg::OUT_USER_W-1:0] m_axis_tuser_o    // span_empty[0]
);
  import fcrs_pkg::*;

  localparam int NSTG = SQRT_STAGES + 4;  // s1, s2, root stages, output

  logic [COL_W-1:0]   cx_q;
  logic [CY_W-1:0]    cy_q;
  logic [RAD_W-1:0]   rad_q;
  logic [COLOR_W-1:0] color_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q    <= CENTER_X_RST;
      cy_q    <= CENTER_Y_RST;
      rad_q   <= RADIUS_RST;
      color_q <= FILL_COLOR_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_CENTER_X:   cx_q    <= cfg_wdata_i[COL_W-1:0];
        REG_CENTER_Y:   cy_q    <= cfg_wdata_i[CY_W-1:0];
        REG_RADIUS:     rad_q   <= cfg_wdata_i[RAD_W-1:0];
        REG_FILL_COLOR: color_q <= cfg_wdata_i[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // valid bits and per-stage load enables
  logic [NSTG-1:0] vld_q, vld_d, en;

  always_comb begin
    en[NSTG-1] = !vld_q[NSTG-1] || m_axis_tready_i;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
    vld_d[0] = s_axis_tvalid_i;
    for (int k = 1; k < NSTG; k++) begin
      vld_d[k] = vld_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (en[k]) vld_q[k] <= vld_d[k];
      end
    end
  end

  assign s_axis_tready_o = en[0];

  // stage 1: band test and |row - cy|
  logic [ROW_W-1:0] in_row;
  logic [ROW_W-1:0] s1_row_q, s1_row_d;
  logic             s1_band_q, s1_band_d;
  logic [CY_W-1:0]  s1_dy_q, s1_dy_d;
  logic [RAD_W:0]   row_ext, cy_ext, rad_ext;

  assign in_row  = s_axis_tdata_i[ROW_W-1:0];
  assign row_ext = {(RAD_W + 1 - ROW_W)'(0), in_row};
  assign cy_ext  = {(RAD_W + 1 - CY_W)'(0), cy_q};
  assign rad_ext = {1'b0, rad_q};

  always_comb begin
    s1_row_d  = in_row;
    s1_band_d = (row_ext + rad_ext >= cy_ext) && (row_ext < cy_ext + rad_ext) &&
                ({(EXT_W - ROW_W)'(0), in_row} < EXT_W'(SCREEN_HEIGHT));
    s1_dy_d   = (in_row >= cy_q) ? in_row - cy_q : cy_q - in_row;
  end

  // stage 2: squares of radius and offset
  logic [ROW_W-1:0]  s2_row_q;
  logic              s2_band_q;
  logic [V_W-1:0]    s2_rr_q;
  logic [2*CY_W-1:0] s2_dd_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s1_row_q  <= s1_row_d;
      s1_band_q <= s1_band_d;
      s1_dy_q   <= s1_dy_d;
    end
    if (en[1]) begin
      s2_row_q  <= s1_row_q;
      s2_band_q <= s1_band_q;
      s2_rr_q   <= {(V_W - RAD_W)'(0), rad_q} * {(V_W - RAD_W)'(0), rad_q};
      s2_dd_q   <= {CY_W'(0), s1_dy_q} * {CY_W'(0), s1_dy_q};
    end
  end

  // root stages: stage 0 holds the radicand, each later one adds two digits
  sqrt_stage_t sq_q [SQRT_STAGES+1];
  sqrt_stage_t sq_d [SQRT_STAGES+1];
  sqrt_stage_t sq_tmp;

  always_comb begin
    sq_d[0].row     = s2_row_q;
    sq_d[0].in_band = s2_band_q;
    sq_d[0].x       = s2_rr_q - {(V_W - 2 * CY_W)'(0), s2_dd_q};
    sq_d[0].q       = '0;
    for (int j = 1; j <= SQRT_STAGES; j++) begin
      sq_tmp = sq_q[j-1];
      for (int k = 0; k < STEPS_PER_STAGE; k++) begin
        sq_tmp = sqrt_step(sq_tmp,
                           unsigned'(ROOT_W - 1 - (j - 1) * STEPS_PER_STAGE - k));
      end
      sq_d[j] = sq_tmp;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j <= SQRT_STAGES; j++) begin
      if (en[j+2]) sq_q[j] <= sq_d[j];
    end
  end

  // output stage: round up for the left edge, clip both edges
  sqrt_stage_t        fin;
  logic [EXT_W-1:0]   cx_ext, s_ext, c_ext, start_ext, end_ext;
  logic               out_empty_d, out_empty_q;
  logic [COL_W-1:0]   out_start_d, out_end_d, out_start_q, out_end_q;
  logic [COLOR_W-1:0] out_color_d, out_color_q;
  logic [ROW_W-1:0]   out_row_q;

  always_comb begin
    fin       = sq_q[SQRT_STAGES];
    cx_ext    = {(EXT_W - COL_W)'(0), cx_q};
    s_ext     = {(EXT_W - ROOT_W)'(0), fin.q};
    c_ext     = s_ext + {(EXT_W - 1)'(0), (fin.x != '0)};
    start_ext = (c_ext > cx_ext) ? '0 : cx_ext - c_ext;
    end_ext   = cx_ext + s_ext;
    if (end_ext > EXT_W'(SCREEN_WIDTH)) end_ext = EXT_W'(SCREEN_WIDTH);
    out_empty_d = !fin.in_band || (start_ext >= end_ext);
    if (out_empty_d) begin
      out_start_d = '0;
      out_end_d   = '0;
      out_color_d = '0;
    end else begin
      out_start_d = start_ext[COL_W-1:0];
      out_end_d   = end_ext[COL_W-1:0];
      out_color_d = color_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[NSTG-1]) begin
      out_row_q   <= fin.row;
      out_start_q <= out_start_d;
      out_end_q   <= out_end_d;
      out_empty_q <= out_empty_d;
      out_color_q <= out_color_d;
    end
  end

  assign m_axis_tvalid_o = vld_q[NSTG-1];
  assign m_axis_tdata_o  = {(OUT_DATA_W - ROW_W - 2 * COL_W - COLOR_W)'(0),
                            out_color_q, out_end_q, out_start_q, out_row_q};
  assign m_axis_tuser_o  = out_empty_q;

  // an empty span carries zero edges and color
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[0] |-> m_axis_tdata_o[36:9] == '0)
    else $error("empty span with nonzero fields");

  // a filled span is well ordered and on screen
  a_span_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o[0] |->
      (out_start_q < out_end_q) &&
      ({(EXT_W - COL_W)'(0), out_end_q} <= EXT_W'(SCREEN_WIDTH)))
    else $error("filled span out of order or off screen");

  // input stalls only when the whole pipe is full behind a held output
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i && (&vld_q))
    else $error("input stalled with room in the pipe");

endmodule

// ===== bench/filled_circle_row_span_top_test.sv =====
// Testbench for filled_circle_row_span_top: streams row indexes through the block and
// checks every span beat against an in-bench span calculator, across several circle setups.
// Depends on fcrs_pkg and the filled_circle_row_span_top RTL.
module filled_circle_row_span_top_test;
  import fcrs_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_PHASES = 10;
  localparam int ROWS_PER_PHASE = 55;
  localparam int OFS_START = ROW_W;
  localparam int OFS_END = ROW_W + COL_W;
  localparam int OFS_COLOR = ROW_W + 2 * COL_W;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] first_col;
    logic [COL_W-1:0] end_col;
    logic empty;
    logic [COLOR_W-1:0] color;
  } span_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic s_valid = 1'b0;
  logic s_ready;
  logic [IN_DATA_W-1:0] s_data = '0;
  logic m_valid;
  logic m_ready = 1'b0;
  logic [OUT_DATA_W-1:0] m_data;
  logic [OUT_USER_W-1:0] m_user;

  // circle setup as the block should hold it
  logic [COL_W-1:0] cx_reg = CENTER_X_RST;
  logic [CY_W-1:0] cy_reg = CENTER_Y_RST;
  logic [RAD_W-1:0] rad_reg = RADIUS_RST;
  logic [COLOR_W-1:0] color_reg = FILL_COLOR_RST;

  logic [ROW_W-1:0] row_q[$];
  span_t span_q[$];
  logic no_idle = 1'b0;
  int mismatches = 0;
  int cycles = 0;

  int rows_reset_cfg[10] = '{0, 139, 140, 141, 240, 339, 340, 479, 480, 511};
  int rows_huge[3] = '{0, 479, 256};
  int rows_corner[2] = '{479, 0};
  int rows_tiny[2] = '{478, 479};
  int rows_left[6] = '{5, 7, 8, 10, 14, 15};

  always #1 clk = ~clk;

  filled_circle_row_span_top dut (
    .clk_i(clk),
    .rst_ni(rst_n),
    .cfg_we_i(cfg_we),
    .cfg_idx_i(cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i(s_data),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o(m_data),
    .m_axis_tuser_o(m_user)
  );

  function automatic int floor_root(int v);
    int s;
    s = 0;
    for (int b = ROOT_W - 1; b >= 0; b--) begin
      if ((s + (1 << b)) * (s + (1 << b)) <= v) s += 1 << b;
    end
    return s;
  endfunction

  function automatic span_t span_for_row(logic [ROW_W-1:0] row);
    int ri, cxi, cyi, r, dy, v, s, c, lo, hi;
    span_t sp;
    ri = int'(row);
    cxi = int'(cx_reg);
    cyi = int'(cy_reg);
    r = int'(rad_reg);
    sp = '0;
    sp.row = row;
    sp.empty = 1'b1;
    if (ri >= cyi - r && ri < cyi + r && ri < SCREEN_HEIGHT) begin
      dy = ri - cyi;
      v = r * r - dy * dy;
      s = floor_root(v);
      c = (s * s != v) ? s + 1 : s;
      lo = (cxi - c < 0) ? 0 : cxi - c;
      hi = (cxi + s > SCREEN_WIDTH) ? SCREEN_WIDTH : cxi + s;
      if (lo < hi) begin
        sp.first_col = COL_W'(lo);
        sp.end_col = COL_W'(hi);
        sp.empty = 1'b0;
        sp.color = color_reg;
      end
    end
    return sp;
  endfunction

  task automatic report_mismatch(string what, int row, int got, int want);
    mismatches++;
    $display("[%0d] row %0d: %s got %0d, want %0d", cycles, row, what, got, want);
  endtask

  task automatic check_field(string what, int row, int got, int want);
    if (got != want) report_mismatch(what, row, got, want);
  endtask

  // drive one register write and track it in the local copy
  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_CENTER_X: cx_reg = val[COL_W-1:0];
      REG_CENTER_Y: cy_reg = val[CY_W-1:0];
      REG_RADIUS: rad_reg = val[RAD_W-1:0];
      REG_FILL_COLOR: color_reg = val[COLOR_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (row_q.size() != 0 || s_valid || span_q.size() != 0);
  endtask

  // row sender
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      s_valid <= 1'b0;
      s_data <= '0;
    end else begin
      if (s_valid && s_ready) span_q.push_back(span_for_row(s_data[ROW_W-1:0]));
      if (!s_valid || s_ready) begin
        if (row_q.size() != 0 && (no_idle || $urandom_range(99) >= 28)) begin
          s_data <= {{(IN_DATA_W - ROW_W){1'b0}}, row_q.pop_front()};
          s_valid <= 1'b1;
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // span receiver and checker
  always @(posedge clk or negedge rst_n) begin : span_check
    span_t want;
    if (!rst_n) begin
      m_ready <= 1'b0;
    end else begin
      if (m_valid && m_ready) begin
        if (span_q.size() == 0) begin
          report_mismatch("beat with no span pending", int'(m_data[ROW_W-1:0]), 0, 0);
        end else begin
          want = span_q.pop_front();
          check_field("row_out", int'(want.row), int'(m_data[ROW_W-1:0]),
                      int'(want.row));
          check_field("span_start", int'(want.row), int'(m_data[OFS_START +: COL_W]),
                      int'(want.first_col));
          check_field("span_end", int'(want.row), int'(m_data[OFS_END +: COL_W]),
                      int'(want.end_col));
          check_field("pixel_color", int'(want.row), int'(m_data[OFS_COLOR +: COLOR_W]),
                      int'(want.color));
          check_field("span_empty", int'(want.row), int'(m_user[0]), int'(want.empty));
        end
      end
      m_ready <= no_idle || $urandom_range(99) >= 28;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout with %0d spans outstanding", span_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int lo, hi;
    logic [RAD_W-1:0] rad;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset geometry: band edges, center row, off-screen rows
    @(negedge clk);
    foreach (rows_reset_cfg[i]) row_q.push_back(ROW_W'(rows_reset_cfg[i]));

    // largest radius from the top-left corner, clipped on the left
    wait_drained();
    set_reg(REG_CENTER_X, '0);
    set_reg(REG_CENTER_Y, '0);
    set_reg(REG_RADIUS, {RAD_W{1'b1}});
    set_reg(REG_FILL_COLOR, {2'b11, 8'h00});
    @(negedge clk);
    foreach (rows_huge[i]) row_q.push_back(ROW_W'(rows_huge[i]));

    // zero radius at the far corner: nothing drawn
    wait_drained();
    set_reg(REG_CENTER_X, COL_W'(SCREEN_WIDTH - 1));
    set_reg(REG_CENTER_Y, {1'b1, CY_W'(SCREEN_HEIGHT - 1)});
    set_reg(REG_RADIUS, '0);
    @(negedge clk);
    foreach (rows_corner[i]) row_q.push_back(ROW_W'(rows_corner[i]));

    // unit radius ending at the right edge; a write to an unused index must be dropped
    wait_drained();
    set_reg(REG_RADIUS, RAD_W'(1));
    set_reg(REG_FILL_COLOR, {2'b00, 8'hFF});
    set_reg(REG_UNUSED_LO, {CFG_W{1'b1}});
    set_reg(REG_UNUSED_HI, '0);
    @(negedge clk);
    foreach (rows_tiny[i]) row_q.push_back(ROW_W'(rows_tiny[i]));

    // small circle at the left edge: exact and inexact roots, zero-width rows
    wait_drained();
    set_reg(REG_CENTER_X, '0);
    set_reg(REG_CENTER_Y, CFG_W'(10));
    set_reg(REG_RADIUS, RAD_W'(5));
    @(negedge clk);
    foreach (rows_left[i]) row_q.push_back(ROW_W'(rows_left[i]));

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_drained();
      no_idle = (ph == 5);
      case ($urandom_range(3))
        0: rad = RAD_W'($urandom_range(15));
        1, 2: rad = RAD_W'($urandom_range(300));
        default: rad = RAD_W'($urandom_range(1023));
      endcase
      set_reg(REG_CENTER_X, COL_W'($urandom_range(SCREEN_WIDTH - 1)));
      set_reg(REG_CENTER_Y, {1'($urandom_range(1)), CY_W'($urandom_range(SCREEN_HEIGHT - 1))});
      set_reg(REG_RADIUS, rad);
      set_reg(REG_FILL_COLOR, {2'($urandom_range(3)), 8'($urandom_range(255))});
      if (ph % 3 == 0)
        set_reg(CFG_IDX_W'($urandom_range(REG_UNUSED_HI, REG_UNUSED_LO)), CFG_W'($urandom));
      @(negedge clk);
      lo = int'(cy_reg) - int'(rad_reg);
      hi = int'(cy_reg) + int'(rad_reg) - 1;
      if (lo < 0) lo = 0;
      if (hi > 511) hi = 511;
      for (int n = 0; n < ROWS_PER_PHASE; n++) begin
        // hold off mid-phase until every span is back
        if (ph == 3 && n == ROWS_PER_PHASE / 2) wait_drained();
        if (lo <= hi && $urandom_range(9) < 8)
          row_q.push_back(ROW_W'($urandom_range(hi, lo)));
        else
          row_q.push_back(ROW_W'($urandom_range(511)));
      end
    end

    wait_drained();
    no_idle = 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
